>>> rtl/wctr_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// wctr_pkg
// Shared types and constants for the weighted channel top-k ranker.
// ---------------------------------------------------------------------------
`default_nettype none

package wctr_pkg;

    // Ranking depth
    localparam int TOP_K    = 5;
    localparam int CNT_W    = $clog2(TOP_K);

    // Field widths
    localparam int FACTOR_W = 16;
    localparam int WEIGHT_W = 16;
    localparam int FREQ_W   = 32;
    localparam int SCORE_W  = 36;
    localparam int PROD_W   = FACTOR_W + WEIGHT_W + 1;
    localparam int RANK_W   = 3;

    // Configuration register map
    localparam int CFG_ADDR_W = 2;
    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_WEIGHT_LEVEL = 2'd0,
        REG_WEIGHT_TIME  = 2'd1,
        REG_WEIGHT_OWNED = 2'd2
    } cfg_reg_e;

    localparam logic [WEIGHT_W-1:0] WEIGHT_RESET = 16'd21845;

    typedef logic signed [SCORE_W-1:0] score_t;
    typedef logic        [FREQ_W-1:0]  freq_t;

    // Input transaction
    typedef struct packed {
        logic signed [FACTOR_W-1:0] signal_level;
        logic signed [FACTOR_W-1:0] time_share;
        logic signed [FACTOR_W-1:0] owned_factor;
        logic        [FREQ_W-1:0]   channel_freq;
        logic                       batch_end;
    } wctr_in_t;

    // Result transaction
    typedef struct packed {
        logic        [RANK_W-1:0]  rank_index;
        logic        [FREQ_W-1:0]  ranked_freq;
        logic signed [SCORE_W-1:0] ranked_score;
        logic                      rank_last;
    } wctr_out_t;

    // Output buffer status toward the pipeline control
    typedef struct packed {
        logic busy;
        logic done;
    } drain_status_t;

endpackage

`default_nettype wire

>>> rtl/weighted_channel_top5_ranker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// weighted_channel_top5_ranker
// Scores channel records by weighted sum and keeps a top-k ranking that is
// emitted in rank order at the end of each batch.
// ---------------------------------------------------------------------------
// Results: the first result of a batch is valid once its last record has passed
//   the product register (loaded on acceptance), then the sum and
//   ranking/snapshot stages; the rest follow one per cycle while m_ready is high.
// Throughput: one record per cycle while s_ready is high; each batch end holds
//   the result buffer until drained, so a following batch end waits for the drain.
// Reset: synchronous active low; weights return to 21845, ranking clears.
`default_nettype none

module weighted_channel_top5_ranker (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            cfg_wr_en,
    input  wire logic [wctr_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  wire logic [wctr_pkg::WEIGHT_W-1:0]   cfg_wdata,
    input  wire logic                            s_valid,
    output logic                                 s_ready,
    input  wire wctr_pkg::wctr_in_t              s_item,
    output logic                                 m_valid,
    input  wire logic                            m_ready,
    output wctr_pkg::wctr_out_t                  m_item
);
    import wctr_pkg::*;

    logic          sc_valid;
    score_t        sc_score;
    freq_t         sc_freq;
    logic          sc_end;
    logic          rank_fire;
    logic          adv;
    drain_status_t drain_st;
    score_t        snap_score [TOP_K];
    freq_t         snap_freq  [TOP_K];

    // A batch-end record waits until the result buffer is free
    assign rank_fire = sc_valid && (!sc_end || !drain_st.busy || drain_st.done);
    assign adv       = !sc_valid || rank_fire;
    assign s_ready   = adv;

    wctr_score u_score (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .in_valid  (s_valid),
        .in_item   (s_item),
        .adv       (adv),
        .sc_valid  (sc_valid),
        .sc_score  (sc_score),
        .sc_freq   (sc_freq),
        .sc_end    (sc_end)
    );

    wctr_rank u_rank (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .fire       (rank_fire),
        .score      (sc_score),
        .freq       (sc_freq),
        .batch_end  (sc_end),
        .snap_score (snap_score),
        .snap_freq  (snap_freq)
    );

    wctr_drain u_drain (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .load       (rank_fire && sc_end),
        .snap_score (snap_score),
        .snap_freq  (snap_freq),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_item     (m_item),
        .status     (drain_st)
    );

endmodule

`default_nettype wire

>>> rtl/wctr_score.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// wctr_score
// Weight registers, product stage and sum stage of the score datapath.
// ---------------------------------------------------------------------------
`default_nettype none

module wctr_score (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        cfg_wr_en,
    input  wire logic [wctr_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  wire logic [wctr_pkg::WEIGHT_W-1:0]   cfg_wdata,
    input  wire logic                        in_valid,
    input  wire wctr_pkg::wctr_in_t          in_item,
    input  wire logic                        adv,
    output logic                             sc_valid,
    output wctr_pkg::score_t                 sc_score,
    output wctr_pkg::freq_t                  sc_freq,
    output logic                             sc_end
);
    import wctr_pkg::*;

    logic [WEIGHT_W-1:0] w_level_reg, w_time_reg, w_owned_reg;

    logic                     p_valid_reg;
    logic signed [PROD_W-1:0] p_level_reg, p_time_reg, p_owned_reg;
    freq_t                    p_freq_reg;
    logic                     p_end_reg;

    logic                     sc_valid_reg;
    score_t                   sc_score_reg;
    freq_t                    sc_freq_reg;
    logic                     sc_end_reg;

    logic signed [PROD_W-1:0] prod_level, prod_time, prod_owned;
    score_t                   sum_next;

    // Weight registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            w_level_reg <= WEIGHT_RESET;
            w_time_reg  <= WEIGHT_RESET;
            w_owned_reg <= WEIGHT_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                REG_WEIGHT_LEVEL: w_level_reg <= cfg_wdata;
                REG_WEIGHT_TIME:  w_time_reg  <= cfg_wdata;
                REG_WEIGHT_OWNED: w_owned_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Signed factor times unsigned weight
    assign prod_level = PROD_W'(in_item.signal_level) * PROD_W'($signed({1'b0, w_level_reg}));
    assign prod_time  = PROD_W'(in_item.time_share)   * PROD_W'($signed({1'b0, w_time_reg}));
    assign prod_owned = PROD_W'(in_item.owned_factor) * PROD_W'($signed({1'b0, w_owned_reg}));

    // Product stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p_valid_reg <= 1'b0;
        end else if (adv) begin
            p_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv && in_valid) begin
            p_level_reg <= prod_level;
            p_time_reg  <= prod_time;
            p_owned_reg <= prod_owned;
            p_freq_reg  <= in_item.channel_freq;
            p_end_reg   <= in_item.batch_end;
        end
    end

    // Sum stage
    assign sum_next = SCORE_W'(p_level_reg) + SCORE_W'(p_time_reg) + SCORE_W'(p_owned_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sc_valid_reg <= 1'b0;
        end else if (adv) begin
            sc_valid_reg <= p_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv && p_valid_reg) begin
            sc_score_reg <= sum_next;
            sc_freq_reg  <= p_freq_reg;
            sc_end_reg   <= p_end_reg;
        end
    end

    assign sc_valid = sc_valid_reg;
    assign sc_score = sc_score_reg;
    assign sc_freq  = sc_freq_reg;
    assign sc_end   = sc_end_reg;

endmodule

`default_nettype wire

>>> rtl/wctr_rank.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// wctr_rank
// Top-k ranking table with registered insertion and batch snapshot.
// ---------------------------------------------------------------------------
`default_nettype none

module wctr_rank (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             fire,
    input  wire wctr_pkg::score_t score,
    input  wire wctr_pkg::freq_t  freq,
    input  wire logic             batch_end,
    output wctr_pkg::score_t      snap_score [wctr_pkg::TOP_K],
    output wctr_pkg::freq_t       snap_freq  [wctr_pkg::TOP_K]
);
    import wctr_pkg::*;

    score_t top_score_reg [TOP_K];
    freq_t  top_freq_reg  [TOP_K];
    score_t top_score_next [TOP_K];
    freq_t  top_freq_next  [TOP_K];

    logic [TOP_K-1:0] cond;
    logic [TOP_K-1:0] hit_above;

    // Slot tests: strict greater, plus tie with the entry above for middle slots
    always_comb begin
        cond[0]       = score > top_score_reg[0];
        cond[TOP_K-1] = score > top_score_reg[TOP_K-1];
        for (int k = 1; k <= TOP_K - 2; k++) begin
            cond[k] = (score > top_score_reg[k]) || (score == top_score_reg[k-1]);
        end
    end

    // Insert at first hit, shift lower entries down
    always_comb begin
        hit_above[0]      = 1'b0;
        top_score_next[0] = cond[0] ? score : top_score_reg[0];
        top_freq_next[0]  = cond[0] ? freq  : top_freq_reg[0];
        for (int i = 1; i < TOP_K; i++) begin
            hit_above[i] = hit_above[i-1] | cond[i-1];
            if (hit_above[i]) begin
                top_score_next[i] = top_score_reg[i-1];
                top_freq_next[i]  = top_freq_reg[i-1];
            end else if (cond[i]) begin
                top_score_next[i] = score;
                top_freq_next[i]  = freq;
            end else begin
                top_score_next[i] = top_score_reg[i];
                top_freq_next[i]  = top_freq_reg[i];
            end
        end
    end

    // Ranking state; batch end clears it as the snapshot is loaded
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < TOP_K; i++) begin
                top_score_reg[i] <= '0;
                top_freq_reg[i]  <= '0;
            end
        end else if (fire) begin
            for (int i = 0; i < TOP_K; i++) begin
                top_score_reg[i] <= batch_end ? '0 : top_score_next[i];
                top_freq_reg[i]  <= batch_end ? '0 : top_freq_next[i];
            end
        end
    end

    assign snap_score = top_score_next;
    assign snap_freq  = top_freq_next;

endmodule

`default_nettype wire

>>> rtl/wctr_drain.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// wctr_drain
// Result buffer: holds one ranking snapshot and shifts it out in rank order.
// ---------------------------------------------------------------------------
`default_nettype none

module wctr_drain (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   load,
    input  wire wctr_pkg::score_t       snap_score [wctr_pkg::TOP_K],
    input  wire wctr_pkg::freq_t        snap_freq  [wctr_pkg::TOP_K],
    output logic                        m_valid,
    input  wire logic                   m_ready,
    output wctr_pkg::wctr_out_t         m_item,
    output wctr_pkg::drain_status_t     status
);
    import wctr_pkg::*;

    score_t            buf_score_reg [TOP_K];
    freq_t             buf_freq_reg  [TOP_K];
    logic [CNT_W-1:0]  cnt_reg;
    logic              busy_reg;
    logic              is_last;
    logic              take;

    assign is_last = cnt_reg == CNT_W'(TOP_K - 1);
    assign take    = busy_reg && m_ready;

    // Control: busy flag and rank counter
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (load) begin
            busy_reg <= 1'b1;
            cnt_reg  <= '0;
        end else if (take) begin
            busy_reg <= !is_last;
            cnt_reg  <= is_last ? '0 : cnt_reg + 1'b1;
        end
    end

    // Snapshot buffer, head entry is the current result
    always_ff @(posedge aclk) begin
        if (load) begin
            buf_score_reg <= snap_score;
            buf_freq_reg  <= snap_freq;
        end else if (take) begin
            for (int i = 0; i < TOP_K - 1; i++) begin
                buf_score_reg[i] <= buf_score_reg[i+1];
                buf_freq_reg[i]  <= buf_freq_reg[i+1];
            end
        end
    end

    assign m_valid             = busy_reg;
    assign m_item.rank_index   = RANK_W'(cnt_reg);
    assign m_item.ranked_freq  = buf_freq_reg[0];
    assign m_item.ranked_score = buf_score_reg[0];
    assign m_item.rank_last    = is_last;

    assign status.busy = busy_reg;
    assign status.done = take && is_last;

endmodule

`default_nettype wire

>>> tb/testbench.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// testbench
// Self-checking bench for weighted_channel_top5_ranker. Channel records go in
// over a valid/ready channel with random gaps. A local predictor scores each
// record with the current weights and keeps its own top-k ranking. At every
// batch end it queues the ranked transactions, and the results are checked
// field by field as they drain under random back-pressure.
// ---------------------------------------------------------------------------

module testbench;
    import wctr_pkg::*;

    localparam int CYCLE_LIMIT    = 200000;
    localparam int SETTLE_CYCLES  = 10;
    localparam int RANDOM_RECORDS = 290;
    localparam int NUM_PHASES     = 6;

    // Index past the register map; writes to it must be ignored
    localparam logic [CFG_ADDR_W-1:0] REG_UNMAPPED = 2'd3;

    // DUT signals; all inputs driven to known values from time zero
    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr  = '0;
    logic [WEIGHT_W-1:0]   cfg_wdata = '0;
    logic                  s_valid   = 1'b0;
    wctr_in_t              s_item    = '0;
    logic                  m_ready   = 1'b0;
    logic                  s_ready;
    logic                  m_valid;
    wctr_out_t             m_item;

    // Predictor state: weights and the ranking table
    logic [WEIGHT_W-1:0] w_level = WEIGHT_RESET;
    logic [WEIGHT_W-1:0] w_time  = WEIGHT_RESET;
    logic [WEIGHT_W-1:0] w_owned = WEIGHT_RESET;
    longint              top_score [TOP_K];
    freq_t               top_freq  [TOP_K];
    wctr_out_t           ranked_q  [$];

    // Run bookkeeping
    int unsigned cycle_cnt     = 0;
    int unsigned records_sent  = 0;
    int unsigned batches_sent  = 0;
    int unsigned ranks_checked = 0;
    int unsigned mismatch_cnt  = 0;
    int          stall_left    = 0;
    bit          tx_gaps_on    = 1'b1;
    bit          rx_stalls_on  = 1'b1;
    wctr_out_t   want;

    weighted_channel_top5_ranker u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_item    (s_item),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_item    (m_item)
    );

    always #5 aclk = ~aclk;

    // Run limit
    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("%0t: timeout, %0d results still pending", $time, ranked_q.size());
            $display("testbench: FAIL");
            $finish;
        end
    end

    // ---------------------------------------------------------------------
    // Predictor
    // ---------------------------------------------------------------------
    function automatic void clear_ranking();
        int k;
        for (k = 0; k < TOP_K; k++) begin
            top_score[k] = 0;
            top_freq[k]  = '0;
        end
    endfunction

    function automatic longint weighted_score(wctr_in_t r);
        return longint'($signed(r.signal_level)) * longint'(w_level)
             + longint'($signed(r.time_share))   * longint'(w_time)
             + longint'($signed(r.owned_factor)) * longint'(w_owned);
    endfunction

    // Strictly above the top, or above entry k / tied with entry k-1 in the
    // middle; the bottom slot only takes a strictly larger score.
    function automatic int rank_slot(longint s);
        int k;
        if (s > top_score[0])
            return 0;
        for (k = 1; k <= TOP_K - 2; k++) begin
            if (s > top_score[k] || s == top_score[k-1])
                return k;
        end
        if (s > top_score[TOP_K-1])
            return TOP_K - 1;
        return TOP_K;
    endfunction

    function automatic void rank_record(wctr_in_t r);
        longint    s;
        int        slot;
        int        k;
        wctr_out_t o;
        s    = weighted_score(r);
        slot = rank_slot(s);
        if (slot < TOP_K) begin
            for (k = TOP_K - 1; k > slot; k--) begin
                top_score[k] = top_score[k-1];
                top_freq[k]  = top_freq[k-1];
            end
            top_score[slot] = s;
            top_freq[slot]  = r.channel_freq;
        end
        if (r.batch_end) begin
            for (k = 0; k < TOP_K; k++) begin
                o.rank_index   = RANK_W'(k);
                o.ranked_freq  = top_freq[k];
                o.ranked_score = top_score[k][SCORE_W-1:0];
                o.rank_last    = (k == TOP_K - 1);
                ranked_q.push_back(o);
            end
            clear_ranking();
        end
    endfunction

    // ---------------------------------------------------------------------
    // Result checker
    // ---------------------------------------------------------------------
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (ranked_q.size() == 0) begin
                $display("%0t: unexpected transaction, expected none, actual %p", $time, m_item);
                mismatch_cnt++;
            end else begin
                want = ranked_q.pop_front();
                ranks_checked++;
                if (m_item.rank_index !== want.rank_index) begin
                    $display("%0t: rank_index expected %0d actual %0d",
                             $time, want.rank_index, m_item.rank_index);
                    mismatch_cnt++;
                end
                if (m_item.ranked_freq !== want.ranked_freq) begin
                    $display("%0t: ranked_freq expected %h actual %h",
                             $time, want.ranked_freq, m_item.ranked_freq);
                    mismatch_cnt++;
                end
                if (m_item.ranked_score !== want.ranked_score) begin
                    $display("%0t: ranked_score expected %0d actual %0d",
                             $time, want.ranked_score, m_item.ranked_score);
                    mismatch_cnt++;
                end
                if (m_item.rank_last !== want.rank_last) begin
                    $display("%0t: rank_last expected %0b actual %0b",
                             $time, want.rank_last, m_item.rank_last);
                    mismatch_cnt++;
                end
            end
        end
    end

    // Mostly short idle runs, now and then a long one
    function automatic int idle_len();
        if ($urandom_range(0, 99) < 85)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Result back-pressure
    always @(negedge aclk) begin
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_ready    <= 1'b0;
        end else if (rx_stalls_on && $urandom_range(0, 99) < 25) begin
            stall_left <= idle_len() - 1;
            m_ready    <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // ---------------------------------------------------------------------
    // Drivers
    // ---------------------------------------------------------------------
    task automatic write_reg(input logic [CFG_ADDR_W-1:0] addr, input logic [WEIGHT_W-1:0] val);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= addr;
        cfg_wdata <= val;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        case (addr)
            REG_WEIGHT_LEVEL: w_level = val;
            REG_WEIGHT_TIME:  w_time  = val;
            REG_WEIGHT_OWNED: w_owned = val;
            default: ;
        endcase
    endtask

    task automatic set_weights(input logic [WEIGHT_W-1:0] lvl, input logic [WEIGHT_W-1:0] tim,
                               input logic [WEIGHT_W-1:0] own);
        write_reg(REG_WEIGHT_LEVEL, lvl);
        write_reg(REG_WEIGHT_TIME, tim);
        write_reg(REG_WEIGHT_OWNED, own);
    endtask

    // One transaction in, then maybe an idle gap
    task automatic send_record(input wctr_in_t r);
        int n;
        @(negedge aclk);
        s_valid <= 1'b1;
        s_item  <= r;
        do @(posedge aclk); while (!s_ready);
        rank_record(r);
        records_sent++;
        if (r.batch_end)
            batches_sent++;
        if (tx_gaps_on && $urandom_range(0, 99) < 30) begin
            n = idle_len();
            @(negedge aclk);
            s_valid <= 1'b0;
            repeat (n - 1) @(negedge aclk);
        end
    endtask

    // Hold the sender until every queued result has drained; settle covers
    // records still in the pipeline that produce nothing.
    task automatic drain_results(input int settle);
        @(negedge aclk);
        s_valid <= 1'b0;
        while (ranked_q.size() != 0)
            @(posedge aclk);
        repeat (settle) @(posedge aclk);
    endtask

    function automatic wctr_in_t make_record(input logic signed [FACTOR_W-1:0] lvl,
                                             input logic signed [FACTOR_W-1:0] tim,
                                             input logic signed [FACTOR_W-1:0] own,
                                             input freq_t freq, input logic last);
        wctr_in_t r;
        r.signal_level = lvl;
        r.time_share   = tim;
        r.owned_factor = own;
        r.channel_freq = freq;
        r.batch_end    = last;
        return r;
    endfunction

    // Full range, small positives, or corner values
    function automatic logic signed [FACTOR_W-1:0] rand_factor();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 50)
            return FACTOR_W'($urandom());
        if (pick < 80)
            return FACTOR_W'($urandom_range(0, 16383));
        case ($urandom_range(0, 4))
            0:       return 16'sh0000;
            1:       return 16'sh8000;
            2:       return 16'sh7FFF;
            3:       return 16'sh2000;
            default: return 16'sh1000;
        endcase
    endfunction

    // Some records repeat the previous factors so scores tie
    function automatic wctr_in_t rand_record(input logic last, input wctr_in_t prev);
        wctr_in_t r;
        r = make_record(rand_factor(), rand_factor(), rand_factor(), $urandom(), last);
        if ($urandom_range(0, 99) < 15) begin
            r.signal_level = prev.signal_level;
            r.time_share   = prev.time_share;
            r.owned_factor = prev.owned_factor;
        end
        return r;
    endfunction

    // ---------------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------------

    // Reset weights; single-record batches with positive, negative and zero
    task automatic test_reset_weights();
        send_record(make_record(16'sd1000, 16'sd1000, 16'sd1000, 32'h0000_0A01, 1'b1));
        send_record(make_record(-16'sd1000, 16'sd0, 16'sd0, 32'h0000_0A02, 1'b1));
        send_record(make_record(16'sd0, 16'sd0, 16'sd0, 32'h0000_0A03, 1'b1));
    endtask

    // Ties, shifting, the equality rule, and a record dropped off the bottom
    task automatic test_tie_scores();
        drain_results(SETTLE_CYCLES);
        send_record(make_record(16'sd100, 16'sd0, 16'sd0, 32'h0000_0B01, 1'b0));
        send_record(make_record(16'sd100, 16'sd0, 16'sd0, 32'h0000_0B02, 1'b0));
        send_record(make_record(16'sd200, 16'sd0, 16'sd0, 32'h0000_0B03, 1'b0));
        send_record(make_record(16'sd100, 16'sd0, 16'sd0, 32'h0000_0B04, 1'b0));
        send_record(make_record(16'sd50, 16'sd0, 16'sd0, 32'h0000_0B05, 1'b0));
        send_record(make_record(16'sd300, 16'sd0, 16'sd0, 32'h0000_0B06, 1'b0));
        send_record(make_record(16'sd100, 16'sd0, 16'sd0, 32'h0000_0B07, 1'b1));
    endtask

    // Factor and weight extremes
    task automatic test_field_extremes();
        drain_results(SETTLE_CYCLES);
        set_weights(16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_record(make_record(16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 32'hFFFF_FFFF, 1'b0));
        send_record(make_record(16'sh8000, 16'sh8000, 16'sh8000, 32'h0000_0000, 1'b0));
        send_record(make_record(16'sh7FFF, 16'sh8000, 16'sh0000, 32'h8000_0001, 1'b0));
        send_record(make_record(16'sh0000, 16'sh0000, 16'sh0001, 32'h0000_0001, 1'b1));
        drain_results(SETTLE_CYCLES);
        set_weights(16'h0000, 16'h0000, 16'h0000);
        send_record(make_record(16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 32'h5555_AAAA, 1'b1));
        drain_results(SETTLE_CYCLES);
        set_weights(16'hFFFF, 16'h0000, 16'h0001);
        send_record(make_record(16'sh0001, 16'sh8000, 16'sh7FFF, 32'hAAAA_5555, 1'b1));
    endtask

    // A write past the register map must leave the weights alone
    task automatic test_unmapped_register();
        drain_results(SETTLE_CYCLES);
        write_reg(REG_UNMAPPED, 16'hFFFF);
        send_record(make_record(16'sh2000, 16'sh2000, 16'sh2000, 32'h0000_0C01, 1'b1));
    endtask

    // Random batches over several weight settings and idle patterns
    task automatic test_random_batches();
        int       phase;
        int       n;
        int       k;
        int       sent_here;
        int       pick;
        wctr_in_t r;
        wctr_in_t prev;
        prev = '0;
        for (phase = 0; phase < NUM_PHASES; phase++) begin
            drain_results(SETTLE_CYCLES);
            tx_gaps_on   = 1'b1;
            rx_stalls_on = 1'b1;
            case (phase)
                0: set_weights(WEIGHT_RESET, WEIGHT_RESET, WEIGHT_RESET);
                2: set_weights(16'hFFFF, 16'hFFFF, 16'hFFFF);
                3: begin
                    // back-to-back stretch, no idling on either side
                    tx_gaps_on   = 1'b0;
                    rx_stalls_on = 1'b0;
                    set_weights(16'($urandom()), 16'($urandom()), 16'($urandom()));
                end
                4: set_weights(16'($urandom_range(0, 255)), 16'($urandom_range(0, 255)),
                               16'($urandom_range(0, 255)));
                default: set_weights(16'($urandom()), 16'($urandom()), 16'($urandom()));
            endcase
            sent_here = 0;
            while (sent_here < RANDOM_RECORDS / NUM_PHASES) begin
                pick = $urandom_range(0, 99);
                if (pick < 70)
                    n = $urandom_range(1, 6);
                else
                    n = $urandom_range(7, 12);
                for (k = 0; k < n; k++) begin
                    r = rand_record(k == n - 1, prev);
                    send_record(r);
                    prev = r;
                    sent_here++;
                end
                // occasionally hold off until the ranker has fully drained
                if ($urandom_range(0, 99) < 8)
                    drain_results(0);
            end
        end
    endtask

    // ---------------------------------------------------------------------
    // Sequence
    // ---------------------------------------------------------------------
    initial begin
        clear_ranking();
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_reset_weights();
        test_tie_scores();
        test_field_extremes();
        test_unmapped_register();
        test_random_batches();

        drain_results(SETTLE_CYCLES);
        $display("Ran %0d channel records in %0d batches, %0d ranked results checked.",
                 records_sent, batches_sent, ranks_checked);
        $display("Weights at reset, zero, full scale and random; ties, drops, negatives.");
        if (mismatch_cnt == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end

endmodule
